// ----- rtl/core/bda_pkg.sv -----
// Shared types and constants for the button debounce and auto-repeat block.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  // Operation carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic CFG_REPEAT_TICKS = 1'b0;
  localparam logic CFG_ACTIVE_LEVEL = 1'b1;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned PinCount   = 3;

  // Reset values.
  localparam logic [CountWidth-1:0] RepeatReset      = 16'd100;
  localparam logic                  ActiveLevelReset = 1'b0;
  localparam logic [PinCount-1:0]   PinsReset        = 3'b111;

  // One input item after unpacking.
  typedef struct packed {
    op_t                op;
    logic [PinCount-1:0] pins;  // bit 0 pin one, bit 2 pin three
    logic [PinCount-1:0] mask;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/button_debounce_auto_repeat.sv -----
// Each item passes from input accept to result valid through the input register, then the result register.
// Throughput: one item per cycle while m_tready does not stall the result; the result register decouples the two sides.
// The update of debounce state and flags, done once per item, sets the rate.
// Reset (rst, synchronous) clears both registers' valid bits, the press flags,
// the history to the inactive level and the repeat counter and register to 100.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_auto_repeat (
  input  wire        clk,
  input  wire        rst,
  // Input items
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // pin_one, pin_two, pin_three, take_mask[2:0], zero pad
  input  wire  [1:0] s_tuser,   // operation[1:0]
  // Result items
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // press_one, press_two, press_three, zero pad
  // Configuration writes
  input  wire        cfg_wr_en,
  input  wire        cfg_index,
  input  wire [15:0] cfg_data
);
  import bda_pkg::*;

  logic                  in_valid;
  item_t                 in_item;
  logic                  out_valid;
  logic [PinCount-1:0]   out_flags;
  logic [PinCount-1:0]   result;
  logic                  slot_free;
  logic                  advance;
  logic [CountWidth-1:0] repeat_ticks;
  logic                  active_level;

  assign slot_free = !out_valid || m_tready;
  assign advance   = in_valid && slot_free;
  assign s_tready  = !in_valid || slot_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_ticks <= RepeatReset;
      active_level <= ActiveLevelReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_REPEAT_TICKS: repeat_ticks <= cfg_data;
        CFG_ACTIVE_LEVEL: active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op   <= op_t'(s_tuser);
      in_item.pins <= s_tdata[2:0];
      in_item.mask <= s_tdata[5:3];
    end
  end

  bda_update u_update (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (in_item),
    .active_level (active_level),
    .repeat_ticks (repeat_ticks),
    .result       (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_flags};

endmodule

`default_nettype wire

// ----- rtl/core/bda_update.sv -----
// Debounce state, repeat counter and press flags, updated once per item.
`timescale 1ns / 1ps
`default_nettype none

module bda_update (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             advance,
  input  bda_pkg::item_t                  item,
  input  wire                             active_level,
  input  wire [bda_pkg::CountWidth-1:0]   repeat_ticks,
  output logic [bda_pkg::PinCount-1:0]    result
);
  import bda_pkg::*;

  logic [2:0]            sample_history, sample_history_next;
  logic                  stable_level, stable_level_next;
  logic [PinCount-1:0]   last_pins, last_pins_next;
  logic [CountWidth-1:0] repeat_count, repeat_count_next;
  logic [PinCount-1:0]   press_flags, press_flags_next;

  logic                  level;
  logic [2:0]            hist_shift;
  logic                  agree;
  logic [CountWidth-1:0] count_dec;
  logic                  raise;
  logic [PinCount-1:0]   raise_bits;
  logic [PinCount-1:0]   pin_hit;

  // Combined level and history shift for a tick.
  always_comb begin
    pin_hit    = ~(item.pins ^ {PinCount{active_level}});
    level      = (|pin_hit) ? active_level : ~active_level;
    hist_shift = {sample_history[1:0], level};
    agree      = (hist_shift[0] == hist_shift[1]) && (hist_shift[1] == hist_shift[2]);
    count_dec  = repeat_count - CountWidth'(1);
  end

  // Fixed priority: the first active pin of the current tick gets the press.
  always_comb begin
    raise_bits = '0;
    priority if (pin_hit[0]) begin
      raise_bits = 3'b001;
    end else if (pin_hit[1]) begin
      raise_bits = 3'b010;
    end else if (pin_hit[2]) begin
      raise_bits = 3'b100;
    end else begin
      raise_bits = '0;
    end
  end

  // Next state and result for the item held in the input register.
  always_comb begin
    sample_history_next = sample_history;
    stable_level_next   = stable_level;
    last_pins_next      = last_pins;
    repeat_count_next   = repeat_count;
    press_flags_next    = press_flags;
    raise               = 1'b0;
    result              = press_flags;
    unique case (item.op)
      OP_TICK: begin
        last_pins_next      = item.pins;
        sample_history_next = hist_shift;
        if (agree) begin
          if (hist_shift[2] != stable_level) begin
            stable_level_next = hist_shift[2];
            if (hist_shift[2] == active_level) begin
              repeat_count_next = repeat_ticks;
              raise             = 1'b1;
            end
          end else if (count_dec == '0) begin
            repeat_count_next = repeat_ticks;
            raise             = (stable_level == active_level);
          end else begin
            repeat_count_next = count_dec;
          end
        end
        press_flags_next = raise ? (press_flags | raise_bits) : press_flags;
        result           = press_flags_next;
      end
      OP_TAKE: begin
        result           = press_flags & item.mask;
        press_flags_next = press_flags & ~item.mask;
      end
      OP_CLEAR: begin
        result           = '0;
        press_flags_next = '0;
      end
      default: begin
        result = press_flags;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_history <= PinsReset;
      stable_level   <= ~ActiveLevelReset;
      last_pins      <= PinsReset;
      repeat_count   <= RepeatReset;
      press_flags    <= '0;
    end else if (advance) begin
      sample_history <= sample_history_next;
      stable_level   <= stable_level_next;
      last_pins      <= last_pins_next;
      repeat_count   <= repeat_count_next;
      press_flags    <= press_flags_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bda_checker.sv -----
// Port-level checks for the button debounce block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bda_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata
);

  // A stalled result item holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // Input is never blocked while the result slot is free.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with a free result slot");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // Padding bits of a result item are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] == 5'b0))
    else $error("result padding not zero");

endmodule

bind button_debounce_auto_repeat bda_checker u_bda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
